// ===== src/motor_command_packet_parser_assert.svh =====
// Assertion macros for the motor command packet parser checker.
// No dependencies; include guarded.
`ifndef MOTOR_COMMAND_PACKET_PARSER_ASSERT_SVH
`define MOTOR_COMMAND_PACKET_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active
`define MCPP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcpp: same-cycle check failed");

// Next-cycle implication, disabled while reset is active
`define MCPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcpp: next-cycle check failed");

`endif

// ===== src/mcpp_pkg.sv =====
// Shared types, character codes and helpers for the motor command packet parser.
// No dependencies.
package mcpp_pkg;

  localparam int CharW  = 8;
  localparam int SpeedW = 16;
  localparam int AccW   = 11;
  localparam int SumW   = 14;
  localparam int PhaseW = 3;

  localparam logic [AccW-1:0] SPEED_MAX = 11'd1023;

  // Parser phases
  localparam logic [PhaseW-1:0] PH_CMD   = 3'd0;
  localparam logic [PhaseW-1:0] PH_COMMA = 3'd1;
  localparam logic [PhaseW-1:0] PH_LEFT  = 3'd2;
  localparam logic [PhaseW-1:0] PH_RIGHT = 3'd3;
  localparam logic [PhaseW-1:0] PH_ERR   = 3'd4;

  // Character codes
  localparam logic [CharW-1:0] CH_S     = 8'h53;
  localparam logic [CharW-1:0] CH_L     = 8'h4C;
  localparam logic [CharW-1:0] CH_R     = 8'h52;
  localparam logic [CharW-1:0] CH_F     = 8'h46;
  localparam logic [CharW-1:0] CH_B     = 8'h42;
  localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;
  localparam logic [CharW-1:0] CH_LF    = 8'h0A;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;

  localparam logic [SpeedW-1:0] TURN_SPEED_RESET = 16'd0;

  // One parsed command
  typedef struct packed {
    logic [CharW-1:0]  command_char;
    logic [SpeedW-1:0] left_speed;
    logic [SpeedW-1:0] right_speed;
    logic              cmd_ok;
  } result_t;

  function automatic logic is_blank(input logic [CharW-1:0] c);
    is_blank = (c == CH_CR) || (c == CH_LF) || (c == CH_SPACE);
  endfunction

  function automatic logic is_moving(input logic [CharW-1:0] c);
    is_moving = (c == CH_F) || (c == CH_B) || (c == CH_L) || (c == CH_R);
  endfunction

endpackage

// ===== src/mcpp_core.sv =====
// Packet state and per-byte parse logic; result is combinational from the byte.
// Depends on mcpp_pkg.
module mcpp_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [mcpp_pkg::CharW-1:0]    char_in,
  input  logic                          last,
  input  logic [mcpp_pkg::SpeedW-1:0]   turn_speed,
  output mcpp_pkg::result_t             result
);

  logic [mcpp_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [mcpp_pkg::CharW-1:0]  first_r, first_nxt;
  logic [1:0]                  count_r, count_nxt;
  logic                        blank_r, blank_nxt;
  logic [mcpp_pkg::AccW-1:0]   lacc_r, lacc_nxt;
  logic [mcpp_pkg::AccW-1:0]   racc_r, racc_nxt;
  logic                        lhas_r, lhas_nxt;
  logic                        rhas_r, rhas_nxt;

  logic                        digit;
  logic [mcpp_pkg::SumW-1:0]   dval;
  logic [mcpp_pkg::SumW-1:0]   lsum;
  logic [mcpp_pkg::SumW-1:0]   rsum;
  logic                        lfit;
  logic                        rfit;

  // acc*10 + digit as two shifts and adds
  assign digit = (char_in >= mcpp_pkg::CH_ZERO) && (char_in <= mcpp_pkg::CH_NINE);
  assign dval  = {{(mcpp_pkg::SumW-4){1'b0}}, char_in[3:0]};
  assign lsum  = ({3'b000, lacc_r} << 3) + ({3'b000, lacc_r} << 1) + dval;
  assign rsum  = ({3'b000, racc_r} << 3) + ({3'b000, racc_r} << 1) + dval;
  assign lfit  = lsum <= {3'b000, mcpp_pkg::SPEED_MAX};
  assign rfit  = rsum <= {3'b000, mcpp_pkg::SPEED_MAX};

  // Next packet state after this byte
  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    count_nxt = count_r;
    blank_nxt = blank_r;
    lacc_nxt  = lacc_r;
    racc_nxt  = racc_r;
    lhas_nxt  = lhas_r;
    rhas_nxt  = rhas_r;
    if (mcpp_pkg::is_blank(char_in)) begin
      if (phase_r == mcpp_pkg::PH_CMD) begin
        first_nxt = char_in;
        phase_nxt = mcpp_pkg::PH_COMMA;
      end
      blank_nxt = 1'b1;
    end else begin
      if (count_r != 2'd2) begin
        count_nxt = count_r + 2'd1;
      end
      if (blank_r) begin
        phase_nxt = mcpp_pkg::PH_ERR;
      end else begin
        unique case (phase_r)
          mcpp_pkg::PH_CMD: begin
            first_nxt = char_in;
            phase_nxt = mcpp_pkg::PH_COMMA;
          end
          mcpp_pkg::PH_COMMA: begin
            phase_nxt = ((char_in == mcpp_pkg::CH_COMMA) && mcpp_pkg::is_moving(first_r))
                        ? mcpp_pkg::PH_LEFT : mcpp_pkg::PH_ERR;
          end
          mcpp_pkg::PH_LEFT: begin
            if (digit) begin
              if (lfit) begin
                lacc_nxt = lsum[mcpp_pkg::AccW-1:0];
                lhas_nxt = 1'b1;
              end else begin
                phase_nxt = mcpp_pkg::PH_ERR;
              end
            end else if ((char_in == mcpp_pkg::CH_COMMA) && lhas_r) begin
              phase_nxt = mcpp_pkg::PH_RIGHT;
            end else begin
              phase_nxt = mcpp_pkg::PH_ERR;
            end
          end
          mcpp_pkg::PH_RIGHT: begin
            if (digit && rfit) begin
              racc_nxt = rsum[mcpp_pkg::AccW-1:0];
              rhas_nxt = 1'b1;
            end else begin
              phase_nxt = mcpp_pkg::PH_ERR;
            end
          end
          default: begin
            phase_nxt = mcpp_pkg::PH_ERR;
          end
        endcase
      end
    end
  end

  // Result as seen after this byte; used only on the last byte
  always_comb begin
    result = '0;
    if (count_nxt != 2'd0) begin
      result.command_char = first_nxt;
      if ((count_nxt == 2'd1) && (phase_nxt == mcpp_pkg::PH_COMMA)) begin
        if (first_nxt == mcpp_pkg::CH_S) begin
          result.cmd_ok = 1'b1;
        end else if ((first_nxt == mcpp_pkg::CH_L) || (first_nxt == mcpp_pkg::CH_R)) begin
          result.left_speed  = turn_speed;
          result.right_speed = turn_speed;
          result.cmd_ok      = 1'b1;
        end
      end else if ((count_nxt == 2'd2) && (phase_nxt == mcpp_pkg::PH_RIGHT) && rhas_nxt) begin
        result.left_speed  = {{(mcpp_pkg::SpeedW-mcpp_pkg::AccW){1'b0}}, lacc_nxt};
        result.right_speed = {{(mcpp_pkg::SpeedW-mcpp_pkg::AccW){1'b0}}, racc_nxt};
        result.cmd_ok      = 1'b1;
      end
    end
  end

  // Packet state; clears at reset and after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      phase_r <= mcpp_pkg::PH_CMD;
      first_r <= '0;
      count_r <= '0;
      blank_r <= 1'b0;
      lacc_r  <= '0;
      racc_r  <= '0;
      lhas_r  <= 1'b0;
      rhas_r  <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      count_r <= count_nxt;
      blank_r <= blank_nxt;
      lacc_r  <= lacc_nxt;
      racc_r  <= racc_nxt;
      lhas_r  <= lhas_nxt;
      rhas_r  <= rhas_nxt;
    end
  end

endmodule

// ===== src/motor_command_packet_parser.sv =====
// Motor command packet parser top level: input register, parse core, result register.
// Depends on mcpp_pkg and mcpp_core.
// A last byte goes through the input register, then the result register, to the outputs.
// Throughput: one byte per cycle; a last byte waits only while a result is stalled.
// The per-byte path is one times-ten add and compare on an 11-bit accumulator.
// Sync reset (rst_n low) empties both registers, clears packet state, loads TURN_SPEED_INIT.
module motor_command_packet_parser #(
  parameter logic [mcpp_pkg::SpeedW-1:0] TURN_SPEED_INIT = mcpp_pkg::TURN_SPEED_RESET
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mcpp_pkg::CharW-1:0]  in_char_in,
  input  logic                        in_end_of_packet,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mcpp_pkg::CharW-1:0]  out_command_char,
  output logic [mcpp_pkg::SpeedW-1:0] out_left_speed,
  output logic [mcpp_pkg::SpeedW-1:0] out_right_speed,
  output logic                        out_cmd_ok,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mcpp_pkg::SpeedW-1:0] cfg_default_turn_speed
);

  logic [mcpp_pkg::SpeedW-1:0] turn_speed_r;
  logic                        s1_valid_r;
  logic [mcpp_pkg::CharW-1:0]  s1_char_r;
  logic                        s1_last_r;
  logic                        out_valid_r;
  mcpp_pkg::result_t           out_res_r;
  mcpp_pkg::result_t           core_res;
  logic                        out_free;
  logic                        s1_adv;
  logic                        in_take;

  // Configuration register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_speed_r <= TURN_SPEED_INIT;
    end else if (cfg_valid && cfg_ready) begin
      turn_speed_r <= cfg_default_turn_speed;
    end
  end

  // Handshake: a middle byte always moves on, a last byte needs a free result slot
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_in;
      s1_last_r <= in_end_of_packet;
    end
  end

  mcpp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (s1_adv),
    .char_in    (s1_char_r),
    .last       (s1_last_r),
    .turn_speed (turn_speed_r),
    .result     (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && s1_last_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command_char = out_res_r.command_char;
  assign out_left_speed   = out_res_r.left_speed;
  assign out_right_speed  = out_res_r.right_speed;
  assign out_cmd_ok       = out_res_r.cmd_ok;

endmodule

// ===== src/mcpp_checker.sv =====
// Port-level checker for the motor command packet parser, bound to the top level.
// Depends on mcpp_pkg and motor_command_packet_parser_assert.svh.
`include "motor_command_packet_parser_assert.svh"

module mcpp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mcpp_pkg::CharW-1:0]  out_command_char,
  input logic [mcpp_pkg::SpeedW-1:0] out_left_speed,
  input logic [mcpp_pkg::SpeedW-1:0] out_right_speed,
  input logic                        out_cmd_ok
);

  // A stalled request stays up
  `MCPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A stalled request keeps its payload
  `MCPP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_command_char) && $stable(out_left_speed) && $stable(out_right_speed) && $stable(out_cmd_ok))

  // Rejected packets carry zero speeds
  `MCPP_ASSERT_NOW(a_bad_zero, out_valid && !out_cmd_ok, (out_left_speed == '0) && (out_right_speed == '0))

  // Accepted packets start with a known command letter
  `MCPP_ASSERT_NOW(a_ok_cmd, out_valid && out_cmd_ok, (out_command_char == mcpp_pkg::CH_S) || (out_command_char == mcpp_pkg::CH_L) || (out_command_char == mcpp_pkg::CH_R) || (out_command_char == mcpp_pkg::CH_F) || (out_command_char == mcpp_pkg::CH_B))

  // Forward and back speeds come from parsed digits and stay in range
  `MCPP_ASSERT_NOW(a_fb_range, out_valid && out_cmd_ok && ((out_command_char == mcpp_pkg::CH_F) || (out_command_char == mcpp_pkg::CH_B)), (out_left_speed <= 16'd1023) && (out_right_speed <= 16'd1023))

endmodule

bind motor_command_packet_parser mcpp_checker u_mcpp_checker (.*);
